// ===== src/sawd_pkg.sv =====
// ----------------------------------------------------------------------------
// sawd_pkg
// Shared types and constants for the sound alarm window detector.
// ----------------------------------------------------------------------------
package sawd_pkg;

  localparam int WINDOW_DEF = 40;

  localparam int LEVEL_W    = 8;
  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 16;
  localparam int LSUM_W     = 14;
  localparam logic [LSUM_W-1:0] LSUM_MAX = {LSUM_W{1'b1}};

  // APB
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MEAN     = 2'd0;
  localparam logic [1:0] REG_PEAK     = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  localparam logic [LEVEL_W-1:0]    MEAN_RST     = 8'd25;
  localparam logic [LEVEL_W-1:0]    PEAK_RST     = 8'd70;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd50;

  typedef struct packed {
    logic [LEVEL_W-1:0]    mean;
    logic [LEVEL_W-1:0]    peak;
    logic [INTERVAL_W-1:0] interval;
    logic                  clr;    // pulse: window clear on register write
  } sawd_cfg_t;

endpackage

// ===== src/sawd_in_if.sv =====
// ----------------------------------------------------------------------------
// sawd_in_if
// Input channel: timer value and sound level, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sawd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [7:0]  sound_level;

  modport source (output valid, output now_ms, output sound_level, input ready);
  modport sink   (input valid, input now_ms, input sound_level, output ready);
endinterface

// ===== src/sawd_out_if.sv =====
// ----------------------------------------------------------------------------
// sawd_out_if
// Result channel: alarm, sample flag and window sum, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sawd_out_if;
  logic        valid;
  logic        ready;
  logic        alarm;
  logic        sample_taken;
  logic [13:0] level_sum;

  modport source (output valid, output alarm, output sample_taken, output level_sum,
                  input ready);
  modport sink   (input valid, input alarm, input sample_taken, input level_sum,
                  output ready);
endinterface

// ===== src/sound_alarm_window_detector.sv =====
// ----------------------------------------------------------------------------
// sound_alarm_window_detector
// Moving window mean and peak threshold detector for a sound level stream.
// ----------------------------------------------------------------------------
// Takes one input transaction per clock and returns one result per input,
// registered, in the cycle after acceptance; throughput stays at one per cycle
// while the result side keeps up. Samples spaced by more than
// sample_interval_ms enter a shift line of WINDOW cells; the oldest one
// drops out of the last cell, and the running sum and the count of samples
// above peak_threshold are corrected in the same cycle. The alarm is
// sum > mean_threshold*WINDOW with at least one sample above the peak.
// Reset clears the window at once (no sweep); any write to a defined
// register also clears it in the cycle of the write. level_sum saturates at
// 16383 when WINDOW makes the exact sum wider than 14 bits.
// ----------------------------------------------------------------------------
module sound_alarm_window_detector #(
  parameter int WINDOW = sawd_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sawd_in_if.sink                     in_if,
  sawd_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sawd_pkg::CFG_AW-1:0] paddr,
  input  logic [sawd_pkg::CFG_DW-1:0] pwdata,
  output logic [sawd_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  localparam int SUM_W = $clog2(WINDOW*255+1);
  localparam int CNT_W = $clog2(WINDOW+1);

  sawd_pkg::sawd_cfg_t cfg;
  logic [SUM_W-1:0]    mean_lim;

  logic [sawd_pkg::TIME_W-1:0]  last_r, last_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt, sum_new;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt, cnt_new;
  logic [sawd_pkg::LEVEL_W-1:0] oldest;
  logic [sawd_pkg::TIME_W-1:0]  elapsed;
  logic [31:0]                  sum_ext;
  logic                         acc, take, old_hi, new_hi, alarm_c;

  logic                         ovld_r, ovld_nxt;
  logic                         alarm_r, taken_r;
  logic [sawd_pkg::LSUM_W-1:0]  lsum_r, lsum_c;

  sawd_cfg #(.WINDOW(WINDOW)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .mean_lim (mean_lim)
  );

  assign in_if.ready = !ovld_r || out_if.ready;
  assign acc         = in_if.valid && in_if.ready;

  assign elapsed = in_if.now_ms - last_r;
  assign take    = elapsed > sawd_pkg::TIME_W'(cfg.interval);

  sawd_window #(.WINDOW(WINDOW)) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (cfg.clr),
    .shift  (acc && take),
    .d_in   (in_if.sound_level),
    .oldest (oldest)
  );

  assign old_hi = oldest > cfg.peak;
  assign new_hi = in_if.sound_level > cfg.peak;

  always_comb begin
    sum_new = sum_r;
    cnt_new = cnt_r;
    if (take) begin
      sum_new = sum_r - SUM_W'(oldest) + SUM_W'(in_if.sound_level);
      cnt_new = cnt_r - CNT_W'(old_hi) + CNT_W'(new_hi);
    end
  end

  assign alarm_c = (sum_new > mean_lim) && (cnt_new != '0);
  assign sum_ext = 32'(sum_new);
  assign lsum_c  = (sum_ext > 32'(sawd_pkg::LSUM_MAX)) ? sawd_pkg::LSUM_MAX
                                                        : sum_ext[sawd_pkg::LSUM_W-1:0];

  always_comb begin
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (cfg.clr) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (acc && take) begin
      sum_nxt  = sum_new;
      cnt_nxt  = cnt_new;
      last_nxt = in_if.now_ms;
    end
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (acc) begin
      ovld_nxt = 1'b1;
    end else if (out_if.ready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      last_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      alarm_r <= alarm_c;
      taken_r <= take;
      lsum_r  <= lsum_c;
    end
  end

  assign out_if.valid        = ovld_r;
  assign out_if.alarm        = alarm_r;
  assign out_if.sample_taken = taken_r;
  assign out_if.level_sum    = lsum_r;

  // count of loud samples can never exceed the window depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW))
    else $error("loud sample count above window depth");

  // window sum stays within what WINDOW samples can hold
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sum_r) <= 32'(WINDOW * 255))
    else $error("window sum out of range");

  // a register write empties the window statistics
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.clr |=> (sum_r == '0) && (cnt_r == '0))
    else $error("window not cleared after register write");

  // a stored sample records its timestamp
  a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && take && !cfg.clr) |=> (last_r == $past(in_if.now_ms)))
    else $error("sample time not recorded");

endmodule

// ===== src/sawd_cell.sv =====
// ----------------------------------------------------------------------------
// sawd_cell
// One window slot: holds a sample, loads its neighbor's value on shift.
// ----------------------------------------------------------------------------
module sawd_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        shift,
  input  logic [sawd_pkg::LEVEL_W-1:0] d,
  output logic [sawd_pkg::LEVEL_W-1:0] q
);

  logic [sawd_pkg::LEVEL_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// ===== src/sawd_window.sv =====
// ----------------------------------------------------------------------------
// sawd_window
// Shift line of WINDOW cells; the last cell holds the oldest sample.
// ----------------------------------------------------------------------------
module sawd_window #(
  parameter int WINDOW = sawd_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic                         shift,
  input  logic [sawd_pkg::LEVEL_W-1:0] d_in,
  output logic [sawd_pkg::LEVEL_W-1:0] oldest
);

  logic [sawd_pkg::LEVEL_W-1:0] tap [WINDOW+1];

  assign tap[0] = d_in;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    sawd_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .clr   (clr),
      .shift (shift),
      .d     (tap[i]),
      .q     (tap[i+1])
    );
  end

  assign oldest = tap[WINDOW];

endmodule

// ===== src/sawd_cfg.sv =====
// ----------------------------------------------------------------------------
// sawd_cfg
// APB register file: thresholds, sample interval, scaled mean threshold.
// ----------------------------------------------------------------------------
module sawd_cfg #(
  parameter int WINDOW = sawd_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sawd_pkg::CFG_AW-1:0] paddr,
  input  logic [sawd_pkg::CFG_DW-1:0] pwdata,
  output logic [sawd_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output sawd_pkg::sawd_cfg_t         cfg,
  output logic [$clog2(WINDOW*255+1)-1:0] mean_lim
);

  localparam int SUM_W = $clog2(WINDOW*255+1);
  localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW);

  logic [sawd_pkg::LEVEL_W-1:0]    mean_r, mean_nxt;
  logic [sawd_pkg::LEVEL_W-1:0]    peak_r, peak_nxt;
  logic [sawd_pkg::INTERVAL_W-1:0] interval_r, interval_nxt;
  logic [SUM_W-1:0]                lim_r, lim_nxt;
  logic [1:0]                      idx;
  logic                            wr, hit;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    mean_nxt     = mean_r;
    peak_nxt     = peak_r;
    interval_nxt = interval_r;
    lim_nxt      = lim_r;
    hit          = 1'b0;
    if (wr) begin
      unique case (idx)
        sawd_pkg::REG_MEAN: begin
          mean_nxt = pwdata[7:0];
          lim_nxt  = SUM_W'(pwdata[7:0]) * WIN_C;
          hit      = 1'b1;
        end
        sawd_pkg::REG_PEAK: begin
          peak_nxt = pwdata[7:0];
          hit      = 1'b1;
        end
        sawd_pkg::REG_INTERVAL: begin
          interval_nxt = pwdata[15:0];
          hit          = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r     <= sawd_pkg::MEAN_RST;
      peak_r     <= sawd_pkg::PEAK_RST;
      interval_r <= sawd_pkg::INTERVAL_RST;
      lim_r      <= SUM_W'(sawd_pkg::MEAN_RST) * WIN_C;
    end else begin
      mean_r     <= mean_nxt;
      peak_r     <= peak_nxt;
      interval_r <= interval_nxt;
      lim_r      <= lim_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      sawd_pkg::REG_MEAN:     prdata = sawd_pkg::CFG_DW'(mean_r);
      sawd_pkg::REG_PEAK:     prdata = sawd_pkg::CFG_DW'(peak_r);
      sawd_pkg::REG_INTERVAL: prdata = sawd_pkg::CFG_DW'(interval_r);
      default:                prdata = '0;
    endcase
  end

  // clear pulses in the write cycle; window logic reacts at the same edge
  assign cfg.mean     = mean_r;
  assign cfg.peak     = peak_r;
  assign cfg.interval = interval_r;
  assign cfg.clr      = hit;
  assign mean_lim     = lim_r;

endmodule
